[design/media_fanout_route_table_core_defines.svh]
// Assertion macros for the route table core
`ifndef MEDIA_FANOUT_ROUTE_TABLE_CORE_DEFINES_SVH
`define MEDIA_FANOUT_ROUTE_TABLE_CORE_DEFINES_SVH
// implication checked every clock outside reset
`define MFRT_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define MFRT_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

[design/mfrt_pkg.sv]
// ----------------------------------------------------------------------------
// mfrt_pkg
// Types and constants shared by the route table core.
// ----------------------------------------------------------------------------
package mfrt_pkg;
   localparam int MAX_PEERS   = 64;
   localparam int MAX_STREAMS = 16;
   localparam int EP_W        = 6;
   localparam int ST_W        = 4;

   localparam logic [1:0] FUNC_REG_PUB  = 2'd0;
   localparam logic [1:0] FUNC_REG_SUB  = 2'd1;
   localparam logic [1:0] FUNC_FORGET   = 2'd2;
   localparam logic [1:0] FUNC_ROUTE    = 2'd3;

   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_FANOUT = 2'd1;
   localparam logic [1:0] ACT_TO_PUB = 2'd2;

   localparam logic [1:0] ROLE_UNKNOWN = 2'd0;
   localparam logic [1:0] ROLE_PUB     = 2'd1;
   localparam logic [1:0] ROLE_SUB     = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [5:0]  endpoint;
      logic [3:0]  stream;
      logic [15:0] session_tag;
      logic        pkt_kind;
      logic        packet_unprotected;
      logic [31:0] ssrc;
      logic [7:0]  pt_code;
   } req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic        peer_hit;
      logic        has_target;
      logic [5:0]  target_endpoint;
      logic [1:0]  source_role;
      logic [3:0]  source_stream;
      logic [15:0] source_session;
      logic        out_kind;
      logic [31:0] out_ssrc;
      logic [7:0]  out_pt_code;
      logic        last;
   } rsp_type;

   // peer memory word
   typedef struct packed {
      logic        is_sub;
      logic [3:0]  stream;
      logic [15:0] session;
   } peer_type;

   // stream memory word
   typedef struct packed {
      logic        pub_valid;
      logic [5:0]  pub_ep;
      logic [63:0] sub_mask;
   } strm_type;
endpackage

[design/media_fanout_route_table_core.sv]
// A protected packet or unknown sender is answered from the peer read in
// S_RD1, a subscriber packet from the stream read in S_RD2, and a publisher
// packet by fanout results from S_SCAN (one target a cycle). Register passes
// through S_RD1, S_RD2 and S_WR; forget through S_RD1 and S_RD2.
// Reset clears peer valid flags and stream init flags; no clearing pass.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// media_fanout_route_table_core
// Peer/stream table with read-modify-write sequencer and fanout scanner.
// ----------------------------------------------------------------------------
`include "media_fanout_route_table_core_defines.svh"
module media_fanout_route_table_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mfrt_pkg::req_type req_data,
   output logic              rsp_valid,
   output mfrt_pkg::rsp_type rsp_data
);
   import mfrt_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD1  = 3'd1;  // peer read returns
   localparam logic [2:0] S_RD2  = 3'd2;  // stream read returns
   localparam logic [2:0] S_WR   = 3'd3;  // second stream update
   localparam logic [2:0] S_SCAN = 3'd4;

   logic [2:0] state_ff, state_in;
   req_type    req_ff;
   peer_type   peer_ff;
   logic       pvalid_ff;
   logic [63:0] mask_ff, mask_in;

   logic       p_rvalid;
   peer_type   p_rdata;
   logic       p_we, p_wv;
   peer_type   p_wd;
   logic [3:0] s_raddr, s_waddr;
   strm_type   s_rdata, s_wd;
   logic       s_we;
   logic       rsp_valid_in;
   rsp_type    rsp_in;

   mfrt_peer_mem u_peer (
      .clock, .reset, .rd_addr(req_data.endpoint), .rd_valid(p_rvalid),
      .rd_data(p_rdata), .wr_en(p_we), .wr_addr(req_ff.endpoint),
      .wr_valid(p_wv), .wr_data(p_wd));

   mfrt_stream_mem u_strm (
      .clock, .reset, .rd_addr(s_raddr), .rd_data(s_rdata), .wr_en(s_we),
      .wr_addr(s_waddr), .wr_data(s_wd));

   assign busy = (state_ff != S_IDLE);

   // lowest set bit of mask
   logic [5:0] low_idx;
   logic       low_any;
   always_comb begin
      low_idx = '0;
      low_any = 1'b0;
      for (int i = MAX_PEERS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            low_idx = 6'(i);
            low_any = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      p_we         = 1'b0;
      p_wv         = 1'b0;
      p_wd         = '0;
      s_raddr      = peer_ff.stream;
      s_we         = 1'b0;
      s_waddr      = peer_ff.stream;
      s_wd         = s_rdata;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.out_kind         = req_ff.pkt_kind;
      rsp_in.out_ssrc         = req_ff.ssrc;
      rsp_in.out_pt_code      = req_ff.pt_code;
      rsp_in.last             = 1'b1;
      rsp_in.peer_hit         = 1'b1;
      rsp_in.source_role      = peer_ff.is_sub ? ROLE_SUB : ROLE_PUB;
      rsp_in.source_stream    = peer_ff.stream;
      rsp_in.source_session   = peer_ff.session;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_RD1;
         end
         S_RD1: begin
            // read old stream row (or route stream)
            s_raddr = p_rdata.stream;
            if (req_ff.func == FUNC_ROUTE &&
                  (!req_ff.packet_unprotected || !p_rvalid)) begin
               rsp_valid_in = 1'b1;
               rsp_in.peer_hit       = 1'b0;
               rsp_in.source_role    = ROLE_UNKNOWN;
               rsp_in.source_stream  = '0;
               rsp_in.source_session = '0;
               rsp_in.action         = ACT_NONE;
               state_in = S_IDLE;
            end else begin
               state_in = S_RD2;
            end
         end
         S_RD2: begin
            // old stream row is in s_rdata
            s_raddr = req_ff.stream;
            if (req_ff.func == FUNC_ROUTE) begin
               if (!peer_ff.is_sub) begin
                  mask_in  = s_rdata.sub_mask & ~(64'd1 << req_ff.endpoint);
                  state_in = S_SCAN;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in.action = req_ff.pkt_kind ? ACT_TO_PUB : ACT_NONE;
                  if (req_ff.pkt_kind && s_rdata.pub_valid &&
                        s_rdata.pub_ep != req_ff.endpoint) begin
                     rsp_in.has_target      = 1'b1;
                     rsp_in.target_endpoint = s_rdata.pub_ep;
                  end
                  state_in = S_IDLE;
               end
            end else begin
               if (pvalid_ff) begin
                  s_we = 1'b1;
                  if (peer_ff.is_sub)
                     s_wd.sub_mask = s_rdata.sub_mask & ~(64'd1 << req_ff.endpoint);
                  else if (s_rdata.pub_ep == req_ff.endpoint)
                     s_wd.pub_valid = 1'b0;
               end
               p_we = 1'b1;
               p_wv = 1'b0;
               state_in = (req_ff.func == FUNC_FORGET) ? S_IDLE : S_WR;
            end
         end
         S_WR: begin
            // new stream row; forward the write just done if same stream
            s_waddr = req_ff.stream;
            s_we    = 1'b1;
            p_we    = 1'b1;
            p_wv    = 1'b1;
            p_wd.is_sub  = (req_ff.func == FUNC_REG_SUB);
            p_wd.stream  = req_ff.stream;
            p_wd.session = req_ff.session_tag;
            if (req_ff.func == FUNC_REG_PUB) begin
               s_wd.pub_valid = 1'b1;
               s_wd.pub_ep    = req_ff.endpoint;
            end else begin
               s_wd.sub_mask = s_rdata.sub_mask | (64'd1 << req_ff.endpoint);
            end
            if (pvalid_ff && peer_ff.stream == req_ff.stream) begin
               if (peer_ff.is_sub) begin
                  s_wd.sub_mask = (s_rdata.sub_mask & ~(64'd1 << req_ff.endpoint))
                     | ((req_ff.func == FUNC_REG_SUB) ? (64'd1 << req_ff.endpoint) : '0);
               end else if (req_ff.func == FUNC_REG_SUB &&
                     s_rdata.pub_ep == req_ff.endpoint) begin
                  s_wd.pub_valid = 1'b0;
               end
            end
            state_in = S_IDLE;
         end
         S_SCAN: begin
            rsp_valid_in = 1'b1;
            rsp_in.action = ACT_FANOUT;
            rsp_in.has_target = low_any;
            rsp_in.target_endpoint = low_idx;
            mask_in = mask_ff & ~(64'd1 << low_idx);
            rsp_in.last = ((mask_ff & ~(64'd1 << low_idx)) == '0);
            if (rsp_in.last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) req_ff <= req_data;
      if (state_ff == S_RD1) begin
         peer_ff   <= p_rdata;
         pvalid_ff <= p_rvalid;
      end
      mask_ff  <= mask_in;
      rsp_data <= rsp_in;
   end

   `MFRT_ASSERT_IMP(a_no_start_busy, clock, reset, busy, state_ff != S_IDLE, "busy mismatch")
   `MFRT_ASSERT_IMP(a_rsp_more, clock, reset, rsp_valid && !rsp_data.last, busy, "rsp")
   `MFRT_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "start not taken")
   `MFRT_ASSERT_IMP(a_scan_ep, clock, reset, state_ff == S_SCAN, !peer_ff.is_sub, "scan sub")
endmodule

[design/mfrt_peer_mem.sv]
// ----------------------------------------------------------------------------
// mfrt_peer_mem
// Peer table: valid flags in flops, entry payload in a synchronous memory.
// ----------------------------------------------------------------------------
module mfrt_peer_mem (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [mfrt_pkg::EP_W-1:0]  rd_addr,
   output logic                       rd_valid,
   output mfrt_pkg::peer_type         rd_data,
   input  logic                       wr_en,
   input  logic [mfrt_pkg::EP_W-1:0]  wr_addr,
   input  logic                       wr_valid,
   input  mfrt_pkg::peer_type         wr_data
);
   import mfrt_pkg::*;

   peer_type   mem [MAX_PEERS];
   logic [MAX_PEERS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en && wr_valid) mem[wr_addr] <= wr_data;
      rd_data  <= mem[rd_addr];
      rd_valid <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= wr_valid;
      end
   end
endmodule

[design/mfrt_stream_mem.sv]
// ----------------------------------------------------------------------------
// mfrt_stream_mem
// Per-stream publisher slot and subscriber mask, synchronous memory.
// ----------------------------------------------------------------------------
module mfrt_stream_mem (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [mfrt_pkg::ST_W-1:0]  rd_addr,
   output mfrt_pkg::strm_type         rd_data,
   input  logic                       wr_en,
   input  logic [mfrt_pkg::ST_W-1:0]  wr_addr,
   input  mfrt_pkg::strm_type         wr_data
);
   import mfrt_pkg::*;

   strm_type mem [MAX_STREAMS];
   logic [MAX_STREAMS-1:0] init_ff;
   strm_type raw_ff;
   logic     init_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      raw_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff    <= '0;
         init_rd_ff <= 1'b0;
      end else begin
         init_rd_ff <= init_ff[rd_addr];
         if (wr_en) init_ff[wr_addr] <= 1'b1;
      end
   end

   // unwritten rows read as empty
   assign rd_data = init_rd_ff ? raw_ff : '0;
endmodule
